@@ hdl/lsr_pkg.sv @@
// Shared constants, types and register codes of the line scanline rasterizer.
`timescale 1ns / 1ps

package lsr_pkg;

	localparam int COORD_BITS   = 12;
	localparam int LINE_BUF_MAX = 1024;
	localparam int INK_W        = 16;

	localparam int IDX_W  = $clog2(LINE_BUF_MAX);
	localparam int LEN_W  = IDX_W + 1;
	localparam int CFG_W  = (INK_W > COORD_BITS) ? INK_W : COORD_BITS;
	localparam int CFG_IDX_W = 3;

	// Working widths: one guard bit on coordinates, three more for the error term.
	localparam int STEP_W = COORD_BITS + 1;
	localparam int ERR_W  = COORD_BITS + 4;
	localparam int SPAN_W = COORD_BITS + 2;

	typedef logic signed [COORD_BITS-1:0] coord_in_t;
	typedef logic signed [STEP_W-1:0]     coord_t;
	typedef logic signed [ERR_W-1:0]      err_t;
	typedef logic signed [ERR_W:0]        err2_t;
	typedef logic signed [SPAN_W-1:0]     span_t;
	typedef logic [LEN_W-1:0]             len_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [INK_W-1:0]             ink_t;
	typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
	typedef logic [CFG_W-1:0]             cfg_data_t;

	localparam cfg_idx_t REG_START_COL = cfg_idx_t'(0);
	localparam cfg_idx_t REG_START_ROW = cfg_idx_t'(1);
	localparam cfg_idx_t REG_END_COL   = cfg_idx_t'(2);
	localparam cfg_idx_t REG_END_ROW   = cfg_idx_t'(3);
	localparam cfg_idx_t REG_INK       = cfg_idx_t'(4);

	localparam len_t LEN_MAX = len_t'(LINE_BUF_MAX);

	typedef struct packed {
		coord_in_t start_col;
		coord_in_t start_row;
		coord_in_t end_col;
		coord_in_t end_row;
		ink_t      ink;
	} lsr_cfg_t;

	// Start values handed from the sequencer to the stepper.
	typedef struct packed {
		logic   start;
		coord_t row;
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		err_t   dx;
		err_t   dy;
		err_t   err;
		logic   sx_neg;
	} lsr_step_cmd_t;

	typedef struct packed {
		logic   done;
		logic   have;
		coord_t lo;
		coord_t hi;
	} lsr_step_sts_t;

endpackage

@@ hdl/lsr_chan_if.sv @@
// Request and result channel interfaces of the line scanline rasterizer.
`timescale 1ns / 1ps

interface lsr_req_if;
	import lsr_pkg::*;

	logic      valid;
	logic      ready;
	coord_in_t scan_row;
	coord_in_t window_col;
	len_t      buffer_length;

	modport source (output valid, output scan_row, output window_col, output buffer_length,
		input ready);
	modport sink (input valid, input scan_row, input window_col, input buffer_length,
		output ready);
endinterface

interface lsr_res_if;
	import lsr_pkg::*;

	logic valid;
	logic ready;
	logic hit;
	idx_t span_first;
	idx_t span_last;
	ink_t pixel_ink;

	modport source (output valid, output hit, output span_first, output span_last,
		output pixel_ink, input ready);
	modport sink (input valid, input hit, input span_first, input span_last,
		input pixel_ink, output ready);
endinterface

@@ hdl/lsr_cfg_regs.sv @@
// Configuration register file: endpoints and ink.
`timescale 1ns / 1ps

module lsr_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  lsr_pkg::cfg_idx_t  cfg_index,
	input  lsr_pkg::cfg_data_t cfg_data,
	output lsr_pkg::lsr_cfg_t  cfg
);
	import lsr_pkg::*;

	lsr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_COL: cfg_q.start_col <= coord_in_t'(cfg_data[COORD_BITS-1:0]);
				REG_START_ROW: cfg_q.start_row <= coord_in_t'(cfg_data[COORD_BITS-1:0]);
				REG_END_COL:   cfg_q.end_col   <= coord_in_t'(cfg_data[COORD_BITS-1:0]);
				REG_END_ROW:   cfg_q.end_row   <= coord_in_t'(cfg_data[COORD_BITS-1:0]);
				REG_INK:       cfg_q.ink       <= cfg_data[INK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/lsr_stepper.sv @@
// Bresenham error stepper: one step per cycle, gathers the run on the wanted row.
`timescale 1ns / 1ps

module lsr_stepper (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  lsr_pkg::lsr_step_cmd_t cmd,
	output lsr_pkg::lsr_step_sts_t sts
);
	import lsr_pkg::*;

	logic   busy_q;
	logic   have_q;
	coord_t x_q, y_q, x1_q, y1_q, row_q, lo_q, hi_q;
	err_t   err_q, dx_q, dy_q;
	logic   sx_neg_q;

	err2_t  e2;
	logic   move_x, move_y, on_row, finish;
	err_t   err_next;

	always_comb begin
		e2       = err2_t'({err_q, 1'b0});
		move_x   = e2 > -err2_t'(dy_q);
		move_y   = e2 < err2_t'(dx_q);
		err_next = err_q - (move_x ? dy_q : err_t'(0)) + (move_y ? dx_q : err_t'(0));
		on_row   = y_q == row_q;
		// Stop once past the row or at the far endpoint, which still counts.
		finish   = (y_q > row_q) || ((x_q == x1_q) && (y_q == y1_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			have_q <= 1'b0;
		end else if (load) begin
			busy_q <= cmd.start;
			have_q <= 1'b0;
		end else if (busy_q) begin
			if (on_row) begin
				have_q <= 1'b1;
			end
			if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q      <= cmd.x0;
			y_q      <= cmd.y0;
			x1_q     <= cmd.x1;
			y1_q     <= cmd.y1;
			row_q    <= cmd.row;
			dx_q     <= cmd.dx;
			dy_q     <= cmd.dy;
			err_q    <= cmd.err;
			sx_neg_q <= cmd.sx_neg;
		end else if (busy_q) begin
			if (on_row) begin
				if (!have_q || x_q < lo_q) begin
					lo_q <= x_q;
				end
				if (!have_q || x_q > hi_q) begin
					hi_q <= x_q;
				end
			end
			if (!finish) begin
				err_q <= err_next;
				if (move_x) begin
					x_q <= sx_neg_q ? x_q - coord_t'(1) : x_q + coord_t'(1);
				end
				if (move_y) begin
					y_q <= y_q + coord_t'(1);
				end
			end
		end
	end

	assign sts.done = busy_q && finish;
	assign sts.have = have_q;
	assign sts.lo   = lo_q;
	assign sts.hi   = hi_q;

endmodule

@@ hdl/line_scanline_rasterizer.sv @@
// Top level of the line scanline rasterizer: sequencer, clipping and result register.
`timescale 1ns / 1ps

// Channel   Dir   Beat contents
// req       in    scan_row, window_col, buffer_length
// res       out   hit, span_first, span_last, pixel_ink
// cfg_*     in    register index and data, one write per enabled cycle
//
// A request passes from acceptance through the setup state, the step state, in which
// the stepper walks Bresenham steps from the upper endpoint down to the requested
// row, and the clip state into the result register. The single stepper advances one
// step per cycle. Rows outside the line skip the step state.
// Reset clears the configuration registers, the sequencer and the result valid flag.
// The block takes one request at a time; a finished result waits in the output
// register, and the next request is accepted while it waits. A result that is still
// waiting when the next one is ready holds the block in the clip state.

module line_scanline_rasterizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  lsr_pkg::cfg_idx_t  cfg_index,
	input  lsr_pkg::cfg_data_t cfg_data,
	lsr_req_if.sink            req,
	lsr_res_if.source          res
);
	import lsr_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_STEP  = 2'd2;
	localparam logic [1:0] ST_CLIP  = 2'd3;

	logic [1:0] state_q;

	lsr_cfg_t      cfg;
	lsr_step_cmd_t step_cmd;
	lsr_step_sts_t step_sts;

	// Request fields, held for the whole walk.
	coord_t row_q;
	span_t  win_q;
	len_t   len_q;

	logic out_valid_q;
	logic hit_q;
	idx_t first_q, last_q;
	ink_t ink_q;

	lsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Setup: order the endpoints so the walk runs downward, then derive the
	// stepper's start values. Equal rows keep the endpoints as written.
	coord_t sx0, sy0, sx1, sy1;
	err_t   xdiff;
	logic   in_range;

	always_comb begin
		if (cfg.start_row > cfg.end_row) begin
			sx0 = coord_t'(cfg.end_col);
			sy0 = coord_t'(cfg.end_row);
			sx1 = coord_t'(cfg.start_col);
			sy1 = coord_t'(cfg.start_row);
		end else begin
			sx0 = coord_t'(cfg.start_col);
			sy0 = coord_t'(cfg.start_row);
			sx1 = coord_t'(cfg.end_col);
			sy1 = coord_t'(cfg.end_row);
		end
		xdiff = err_t'(sx1) - err_t'(sx0);

		step_cmd.x0     = sx0;
		step_cmd.y0     = sy0;
		step_cmd.x1     = sx1;
		step_cmd.y1     = sy1;
		step_cmd.row    = row_q;
		step_cmd.dx     = (xdiff < err_t'(0)) ? -xdiff : xdiff;
		step_cmd.dy     = err_t'(sy1) - err_t'(sy0);
		step_cmd.err    = step_cmd.dx - step_cmd.dy;
		step_cmd.sx_neg = !(sx0 < sx1);

		in_range       = (row_q >= sy0) && (row_q <= sy1) && (len_q != '0);
		step_cmd.start = in_range;
	end

	lsr_stepper u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (state_q == ST_SETUP),
		.cmd    (step_cmd),
		.sts    (step_sts)
	);

	// Clipping: shift the run into buffer indices and trim it to the buffer.
	span_t a_idx, b_idx, last_idx;
	logic  clip_hit;
	idx_t  clip_first, clip_last;
	logic  out_load;

	always_comb begin
		a_idx      = span_t'(step_sts.lo) - win_q;
		b_idx      = span_t'(step_sts.hi) - win_q;
		last_idx   = span_t'(len_q) - span_t'(1);
		clip_hit   = step_sts.have && (b_idx >= span_t'(0)) && (a_idx <= last_idx);
		clip_first = (a_idx < span_t'(0)) ? '0 : a_idx[IDX_W-1:0];
		clip_last  = (b_idx > last_idx) ? last_idx[IDX_W-1:0] : b_idx[IDX_W-1:0];
		out_load   = (state_q == ST_CLIP) && (!out_valid_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= in_range ? ST_STEP : ST_CLIP;
				end
				ST_STEP: begin
					if (step_sts.done) begin
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			row_q <= coord_t'(req.scan_row);
			win_q <= span_t'(req.window_col);
			len_q <= (req.buffer_length > LEN_MAX) ? LEN_MAX : req.buffer_length;
		end
		if (out_load) begin
			hit_q   <= clip_hit;
			first_q <= clip_hit ? clip_first : '0;
			last_q  <= clip_hit ? clip_last : '0;
			ink_q   <= cfg.ink;
		end
	end

	assign req.ready      = state_q == ST_IDLE;
	assign res.valid      = out_valid_q;
	assign res.hit        = hit_q;
	assign res.span_first = first_q;
	assign res.span_last  = last_q;
	assign res.pixel_ink  = ink_q;

`ifndef SYNTHESIS
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.hit |-> res.span_first <= res.span_last)
		else $error("span_first above span_last on a hit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.hit |-> res.span_first == '0 && res.span_last == '0)
		else $error("span fields not cleared on a miss");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_SETUP)
		else $error("accepted beat did not start setup");

	a_done_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_sts.done |-> state_q == ST_STEP)
		else $error("stepper finished outside the step state");

	a_setup_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP |=> state_q == ST_STEP || state_q == ST_CLIP)
		else $error("setup lasted more than one cycle");
`endif

endmodule
